>>> sv/cyk_pkg.sv
// Shared types and constants of the CYK parse tree counter.
// Used by the controller, the datapath, the modular multiplier and the top level.
`default_nettype none

package cyk_pkg;

   localparam logic [1:0] CMD_TERM = 2'd0;
   localparam logic [1:0] CMD_BIN  = 2'd1;
   localparam logic [1:0] CMD_WORD = 2'd2;

   localparam logic [29:0] CYK_MODULUS = 30'd1000000007;
   localparam logic [4:0]  START_SYMBOL_RESET = 5'd18;

   typedef struct packed {
      logic [1:0] command;
      logic [4:0] lhs;
      logic [7:0] symbol;
      logic [4:0] left_child;
      logic [4:0] right_child;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [29:0] tree_count;
      logic        word_overflow;
      logic        rule_overflow;
   } rsp_type;

   typedef struct packed {
      logic       binary;
      logic [4:0] lhs;
      logic [7:0] symbol;
      logic [4:0] left_child;
      logic [4:0] right_child;
   } rule_entry_type;

   typedef struct packed {
      logic rule_we;
      logic word_we;
      logic acc_clear;
      logic acc_set;
      logic acc_add;
      logic tab_we;
      logic mul_start;
      logic final_rd;
   } dp_cmd_type;

   typedef struct packed {
      logic rule_binary;
      logic leaf_match;
      logic operand_zero;
      logic mul_done;
   } dp_status_type;

endpackage

`default_nettype wire

>>> sv/cyk_modmul.sv
// Bit-serial modular multiplier, one multiplier bit per cycle.
// Depends on cyk_pkg for the modulus.
`default_nettype none

module cyk_modmul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [29:0] a,
   input  wire logic [29:0] b,
   output logic             done,
   output logic [29:0]      product
);
   import cyk_pkg::*;

   localparam logic [31:0] MOD1 = {2'b00, CYK_MODULUS};
   localparam logic [31:0] MOD2 = {1'b0, CYK_MODULUS, 1'b0};

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [29:0] a_ff, a_in;
   logic [29:0] b_ff, b_in;
   logic [29:0] r_ff, r_in;
   logic [31:0] t;

   // Horner step: r = 2r + bit*b, then bring it back below the modulus.
   always_comb begin
      t = {1'b0, r_ff, 1'b0} + (a_ff[29] ? {2'b00, b_ff} : 32'd0);
      if (t >= MOD2) begin
         t = t - MOD2;
      end else if (t >= MOD1) begin
         t = t - MOD1;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd29;
         a_in    = a;
         b_in    = b;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in = t[29:0];
         a_in = {a_ff[28:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

`default_nettype wire

>>> sv/cyk_dp.sv
// Datapath of the CYK counter: rule, word and span count memories,
// per-nonterminal accumulators and the modular multiply-add.
// Depends on cyk_pkg and cyk_modmul.
`default_nettype none

module cyk_dp #(
   parameter int MAX_WORD     = 32,
   parameter int MAX_RULES    = 64,
   parameter int NONTERMINALS = 26,
   localparam int WI  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1,
   localparam int RI  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
   localparam int NTW = (NONTERMINALS > 1) ? $clog2(NONTERMINALS) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cyk_pkg::dp_cmd_type    cmd,
   input  wire cyk_pkg::req_type       req_item,
   input  wire logic [RI-1:0]          rule_addr,
   input  wire logic [WI-1:0]          word_addr,
   input  wire logic [WI-1:0]          i_idx,
   input  wire logic [WI-1:0]          q_idx,
   input  wire logic [WI-1:0]          j_idx,
   input  wire logic [NTW-1:0]         x_idx,
   input  wire logic [NTW-1:0]         start_idx,
   output cyk_pkg::dp_status_type      status,
   output logic [29:0]                 final_count
);
   import cyk_pkg::*;

   localparam int TAW = NTW + 2 * WI;
   localparam int TAB_DEPTH = 2 ** TAW;

   rule_entry_type rule_mem [MAX_RULES];
   logic [7:0]     word_mem [MAX_WORD];
   logic [29:0]    tab_mem  [TAB_DEPTH];
   logic [29:0]    acc_ff   [NONTERMINALS];

   rule_entry_type rule_rd_ff;
   logic [7:0]     word_rd_ff;
   logic [29:0]    tab_l_ff;
   logic [29:0]    tab_r_ff;

   rule_entry_type rule_wdata;
   logic [TAW-1:0] tab_l_addr, tab_r_addr, tab_w_addr;
   logic [NTW-1:0] lhs_idx, acc_idx;
   logic [29:0]    acc_rd, acc_sum;
   logic [30:0]    sum_wide;
   logic           mul_done;
   logic [29:0]    mul_product;

   always_comb begin
      rule_wdata.binary      = (req_item.command == CMD_BIN);
      rule_wdata.lhs         = req_item.lhs;
      rule_wdata.symbol      = req_item.symbol;
      rule_wdata.left_child  = rule_wdata.binary ? req_item.left_child : 5'd0;
      rule_wdata.right_child = rule_wdata.binary ? req_item.right_child : 5'd0;
   end

   always_ff @(posedge clock) begin
      if (cmd.rule_we) begin
         rule_mem[rule_addr] <= rule_wdata;
      end
      rule_rd_ff <= rule_mem[rule_addr];
      if (cmd.word_we) begin
         word_mem[word_addr] <= req_item.symbol;
      end
      word_rd_ff <= word_mem[word_addr];
   end

   assign lhs_idx = rule_rd_ff.lhs[NTW-1:0];
   assign acc_idx = cmd.tab_we ? x_idx : lhs_idx;
   assign acc_rd  = acc_ff[acc_idx];

   always_comb begin
      tab_w_addr = {x_idx, i_idx, j_idx};
      if (cmd.final_rd) begin
         tab_l_addr = {start_idx, {WI{1'b0}}, j_idx};
      end else begin
         tab_l_addr = {rule_rd_ff.left_child[NTW-1:0], i_idx, q_idx};
      end
      tab_r_addr = {rule_rd_ff.right_child[NTW-1:0], WI'(q_idx + WI'(1)), j_idx};
   end

   always_ff @(posedge clock) begin
      if (cmd.tab_we) begin
         tab_mem[tab_w_addr] <= acc_rd;
      end
      tab_l_ff <= tab_mem[tab_l_addr];
      tab_r_ff <= tab_mem[tab_r_addr];
   end

   cyk_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (tab_l_ff),
      .b       (tab_r_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   always_comb begin
      sum_wide = {1'b0, acc_rd} + {1'b0, mul_product};
      if (sum_wide >= {1'b0, CYK_MODULUS}) begin
         sum_wide = sum_wide - {1'b0, CYK_MODULUS};
      end
      acc_sum = sum_wide[29:0];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NONTERMINALS; k++) begin
         if (cmd.acc_clear) begin
            acc_ff[k] <= '0;
         end
      end
      if (cmd.acc_set) begin
         acc_ff[lhs_idx] <= 30'd1;
      end else if (cmd.acc_add) begin
         acc_ff[lhs_idx] <= acc_sum;
      end
   end

   assign status.rule_binary  = rule_rd_ff.binary;
   assign status.leaf_match   = !rule_rd_ff.binary && (rule_rd_ff.symbol == word_rd_ff);
   assign status.operand_zero = (tab_l_ff == 30'd0) || (tab_r_ff == 30'd0);
   assign status.mul_done     = mul_done;
   assign final_count         = tab_l_ff;

endmodule

`default_nettype wire

>>> sv/cyk_ctrl.sv
// Controller of the CYK counter: item loading, store counts, the fill
// sequencer over spans, rules and split points, and the result register.
// Depends on cyk_pkg.
`default_nettype none

module cyk_ctrl #(
   parameter int MAX_WORD     = 32,
   parameter int MAX_RULES    = 64,
   parameter int NONTERMINALS = 26,
   localparam int WI  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1,
   localparam int RI  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
   localparam int NTW = (NONTERMINALS > 1) ? $clog2(NONTERMINALS) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire cyk_pkg::req_type       req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output cyk_pkg::rsp_type            rsp_item,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [4:0]             csr_data,
   output cyk_pkg::dp_cmd_type         cmd,
   input  wire cyk_pkg::dp_status_type status,
   input  wire logic [29:0]            final_count,
   output logic [RI-1:0]               rule_addr,
   output logic [WI-1:0]               word_addr,
   output logic [WI-1:0]               i_idx,
   output logic [WI-1:0]               q_idx,
   output logic [WI-1:0]               j_idx,
   output logic [NTW-1:0]              x_idx,
   output logic [NTW-1:0]              start_idx
);
   import cyk_pkg::*;

   localparam int WL  = $clog2(MAX_WORD + 1);
   localparam int RCW = $clog2(MAX_RULES + 1);
   localparam logic [4:0] NT_LIMIT = 5'(NONTERMINALS);

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b000000000001,
      ST_START     = 12'b000000000010,
      ST_SPAN_INIT = 12'b000000000100,
      ST_RULE_RD   = 12'b000000001000,
      ST_RULE_CHK  = 12'b000000010000,
      ST_TAB_RD    = 12'b000000100000,
      ST_MUL_CHK   = 12'b000001000000,
      ST_MUL_WAIT  = 12'b000010000000,
      ST_WRITE     = 12'b000100000000,
      ST_FINAL_RD  = 12'b001000000000,
      ST_FINAL_WT  = 12'b010000000000,
      ST_DONE      = 12'b100000000000
   } state_type;

   state_type      state_ff, state_in;
   logic [RCW-1:0] rule_total_ff, rule_total_in;
   logic [WL-1:0]  word_length_ff, word_length_in;
   logic           word_ovf_ff, word_ovf_in;
   logic           rule_ovf_ff, rule_ovf_in;
   logic [4:0]     start_ff;
   logic           zero_ff, zero_in;
   logic [WI-1:0]  len_ff, len_in;
   logic [WI-1:0]  i_ff, i_in;
   logic [WI-1:0]  q_ff, q_in;
   logic [RI-1:0]  r_ff, r_in;
   logic [NTW-1:0] x_ff, x_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_item_ff, rsp_item_in;

   logic           accept, out_free, nt_ok, is_rule;
   logic [WI-1:0]  j_cur;
   logic           last_rule, last_split;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign is_rule = (req_item.command == CMD_TERM) || (req_item.command == CMD_BIN);
   assign nt_ok   = (req_item.lhs < NT_LIMIT) &&
                    ((req_item.command != CMD_BIN) ||
                     ((req_item.left_child < NT_LIMIT) && (req_item.right_child < NT_LIMIT)));

   assign j_cur      = WI'(i_ff + len_ff);
   assign last_rule  = ((RCW'(r_ff) + RCW'(1)) == rule_total_ff);
   assign last_split = (WI'(q_ff + WI'(1)) == j_cur);

   always_comb begin
      state_in       = state_ff;
      rule_total_in  = rule_total_ff;
      word_length_in = word_length_ff;
      word_ovf_in    = word_ovf_ff;
      rule_ovf_in    = rule_ovf_ff;
      zero_in        = zero_ff;
      len_in         = len_ff;
      i_in           = i_ff;
      q_in           = q_ff;
      r_in           = r_ff;
      x_in           = x_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_item_in    = rsp_item_ff;
      cmd            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_rule && nt_ok) begin
                  if (rule_total_ff < RCW'(MAX_RULES)) begin
                     cmd.rule_we   = 1'b1;
                     rule_total_in = rule_total_ff + RCW'(1);
                  end else begin
                     rule_ovf_in = 1'b1;
                  end
               end else if (req_item.command == CMD_WORD) begin
                  if (word_length_ff < WL'(MAX_WORD)) begin
                     cmd.word_we    = 1'b1;
                     word_length_in = word_length_ff + WL'(1);
                  end else begin
                     word_ovf_in = 1'b1;
                  end
                  if (req_item.last) begin
                     state_in = ST_START;
                  end
               end
            end
         end
         ST_START: begin
            len_in = '0;
            i_in   = '0;
            if ((word_length_ff == '0) || (start_ff >= NT_LIMIT)) begin
               zero_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               zero_in  = 1'b0;
               state_in = ST_SPAN_INIT;
            end
         end
         ST_SPAN_INIT: begin
            cmd.acc_clear = 1'b1;
            r_in = '0;
            x_in = '0;
            state_in = (rule_total_ff == '0) ? ST_WRITE : ST_RULE_RD;
         end
         ST_RULE_RD: begin
            state_in = ST_RULE_CHK;
         end
         ST_RULE_CHK: begin
            if ((len_ff == '0) || !status.rule_binary) begin
               if (len_ff == '0) begin
                  cmd.acc_set = status.leaf_match;
               end
               if (last_rule) begin
                  state_in = ST_WRITE;
               end else begin
                  r_in     = RI'(r_ff + RI'(1));
                  state_in = ST_RULE_RD;
               end
            end else begin
               q_in     = i_ff;
               state_in = ST_TAB_RD;
            end
         end
         ST_TAB_RD: begin
            state_in = ST_MUL_CHK;
         end
         ST_MUL_CHK, ST_MUL_WAIT: begin
            if ((state_ff == ST_MUL_CHK) && !status.operand_zero) begin
               cmd.mul_start = 1'b1;
               state_in      = ST_MUL_WAIT;
            end else if ((state_ff == ST_MUL_CHK) || status.mul_done) begin
               cmd.acc_add = (state_ff == ST_MUL_WAIT);
               if (!last_split) begin
                  q_in     = WI'(q_ff + WI'(1));
                  state_in = ST_TAB_RD;
               end else if (last_rule) begin
                  state_in = ST_WRITE;
               end else begin
                  r_in     = RI'(r_ff + RI'(1));
                  state_in = ST_RULE_RD;
               end
            end
         end
         ST_WRITE: begin
            cmd.tab_we = 1'b1;
            if (x_ff != NTW'(NONTERMINALS - 1)) begin
               x_in = NTW'(x_ff + NTW'(1));
            end else if ((WL'(i_ff) + WL'(len_ff) + WL'(1)) < word_length_ff) begin
               i_in     = WI'(i_ff + WI'(1));
               state_in = ST_SPAN_INIT;
            end else if ((WL'(len_ff) + WL'(1)) < word_length_ff) begin
               len_in   = WI'(len_ff + WI'(1));
               i_in     = '0;
               state_in = ST_SPAN_INIT;
            end else begin
               state_in = ST_FINAL_RD;
            end
         end
         ST_FINAL_RD: begin
            cmd.final_rd = 1'b1;
            state_in     = ST_FINAL_WT;
         end
         ST_FINAL_WT, ST_DONE: begin
            cmd.final_rd = 1'b1;
            if (state_ff == ST_FINAL_WT) begin
               state_in = ST_DONE;
            end else if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_item_in.tree_count    = zero_ff ? 30'd0 : final_count;
               rsp_item_in.word_overflow = word_ovf_ff;
               rsp_item_in.rule_overflow = rule_ovf_ff;
               rule_total_in  = '0;
               word_length_in = '0;
               word_ovf_in    = 1'b0;
               rule_ovf_in    = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rule_total_ff  <= '0;
         word_length_ff <= '0;
         word_ovf_ff    <= 1'b0;
         rule_ovf_ff    <= 1'b0;
         start_ff       <= START_SYMBOL_RESET;
         rsp_valid_ff   <= 1'b0;
         zero_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rule_total_ff  <= rule_total_in;
         word_length_ff <= word_length_in;
         word_ovf_ff    <= word_ovf_in;
         rule_ovf_ff    <= rule_ovf_in;
         rsp_valid_ff   <= rsp_valid_in;
         zero_ff        <= zero_in;
         if (csr_valid && csr_ready) begin
            start_ff <= csr_data;
         end
      end
      len_ff      <= len_in;
      i_ff        <= i_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      x_ff        <= x_in;
      rsp_item_ff <= rsp_item_in;
   end

   // The single-port rule and word stores are addressed by the fill counters
   // during a computation and by the store counts while loading.
   assign rule_addr = (state_ff == ST_IDLE) ? rule_total_ff[RI-1:0] : r_ff;
   assign word_addr = (state_ff == ST_IDLE) ? word_length_ff[WI-1:0] : i_ff;
   assign i_idx     = i_ff;
   assign q_idx     = q_ff;
   assign j_idx     = cmd.final_rd ? WI'(word_length_ff - WL'(1)) : j_cur;
   assign x_idx     = x_ff;
   assign start_idx = start_ff[NTW-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_rule_total_bound: assert property (@(posedge clock) disable iff (reset)
      rule_total_ff <= RCW'(MAX_RULES))
      else $error("rule count beyond store depth");

   a_word_length_bound: assert property (@(posedge clock) disable iff (reset)
      word_length_ff <= WL'(MAX_WORD))
      else $error("word length beyond store depth");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> (state_ff == ST_MUL_WAIT))
      else $error("multiplier finished outside its wait state");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=>
         (rule_total_ff == '0 && word_length_ff == '0 && rsp_valid_ff))
      else $error("stores not cleared when the result was issued");
`endif

endmodule

`default_nettype wire

>>> sv/cyk_parse_tree_counter.sv
// CYK parse tree counter: rule and letter loads are taken one item per cycle while idle.
// The item with the last letter leads to a start step, then the span table fill: per span,
// an accumulator clear, a pass over the rule store (a read and a check per rule) plus, per
// binary rule and split, a table read and a check, and a serial multiply when both operands
// are nonzero, and NONTERMINALS table writes. The final read states then issue the result.
// Synchronous reset empties the stores, clears the flags and sets the start symbol to 18.
`default_nettype none

module cyk_parse_tree_counter #(
   parameter int MAX_WORD     = 32,
   parameter int MAX_RULES    = 64,
   parameter int NONTERMINALS = 26
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cyk_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cyk_pkg::rsp_type      rsp_item,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [4:0]       csr_data
);
   import cyk_pkg::*;

   localparam int WI  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int RI  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int NTW = (NONTERMINALS > 1) ? $clog2(NONTERMINALS) : 1;

   // The controller owns the fill and store counters and the result register; the datapath
   // owns the memories, the accumulators and the modular arithmetic. Each span
   // is accumulated in per-nonterminal registers and written to the table only
   // when complete, so every table entry is written before it is ever read.
   dp_cmd_type    cmd;
   dp_status_type status;
   logic [29:0]   final_count;
   logic [RI-1:0] rule_addr;
   logic [WI-1:0] word_addr, i_idx, q_idx, j_idx;
   logic [NTW-1:0] x_idx, start_idx;

   cyk_ctrl #(
      .MAX_WORD     (MAX_WORD),
      .MAX_RULES    (MAX_RULES),
      .NONTERMINALS (NONTERMINALS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .final_count (final_count),
      .rule_addr   (rule_addr),
      .word_addr   (word_addr),
      .i_idx       (i_idx),
      .q_idx       (q_idx),
      .j_idx       (j_idx),
      .x_idx       (x_idx),
      .start_idx   (start_idx)
   );

   cyk_dp #(
      .MAX_WORD     (MAX_WORD),
      .MAX_RULES    (MAX_RULES),
      .NONTERMINALS (NONTERMINALS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_item    (req_item),
      .rule_addr   (rule_addr),
      .word_addr   (word_addr),
      .i_idx       (i_idx),
      .q_idx       (q_idx),
      .j_idx       (j_idx),
      .x_idx       (x_idx),
      .start_idx   (start_idx),
      .status      (status),
      .final_count (final_count)
   );

endmodule

`default_nettype wire
